// ===== sv/dhss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhss_pkg
// Shared types and constants for the Diffie-Hellman shared-secret block.
// ----------------------------------------------------------------------------
package dhss_pkg;

  // Default modulus width and the fixed private key width.
  localparam int unsigned MOD_BITS_DEF = 31;
  localparam int unsigned KEY_BITS     = 31;
  localparam int unsigned KEY_IDX_W    = $clog2(KEY_BITS);

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_MODULUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR     = 1'd1;
  localparam longint unsigned PRIME_RESET = 64'd23;
  localparam longint unsigned GEN_RESET   = 64'd5;

  // Exponentiation passes, in the order they run.
  typedef enum logic [1:0] {
    PH_PUB_A = 2'd0,
    PH_PUB_B = 2'd1,
    PH_SEC_A = 2'd2,
    PH_SEC_B = 2'd3
  } phase_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP      = 4'd0,
    DP_LOAD     = 4'd1,
    DP_RED      = 4'd2,
    DP_EXP_INIT = 4'd3,
    DP_SQ_INIT  = 4'd4,
    DP_MP_INIT  = 4'd5,
    DP_MUL_STEP = 4'd6,
    DP_MUL_DONE = 4'd7,
    DP_STORE    = 4'd8,
    DP_FINISH   = 4'd9
  } dp_op_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_RED      = 4'd1,
    ST_EXP_INIT = 4'd2,
    ST_SQ_INIT  = 4'd3,
    ST_MP_INIT  = 4'd4,
    ST_MUL_RUN  = 4'd5,
    ST_MUL_DONE = 4'd6,
    ST_STORE    = 4'd7,
    ST_FINISH   = 4'd8
  } state_t;

  typedef struct packed {
    dp_op_t op;
    phase_t phase;
    logic   shift_key;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_small;
    logic key_bit;
  } dp_status_t;

endpackage

// ===== sv/diffie_hellman_shared_secret.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diffie_hellman_shared_secret
// Usage: write prime_modulus (index 0) and generator (index 1) on the cfg
// port while idle; they reset to 23 and 5. An input transfer carries both
// private keys. The block reduces the generator mod p, then runs four
// square-and-multiply exponentiations (both public keys, then both partial
// secrets) on one bit-serial modular multiplier, one pass per square or
// multiply. One result transfer follows per input transfer with both public
// keys, the shared secret and the agreement flag. A modulus below two skips
// the arithmetic and gives zero public keys and a zero secret.
// One item is in work at a time; in_stall is high from acceptance until the
// result sits in the output register. If the receiver stalls, the result
// holds and the next item may run but waits before its finish step.
// Reset is synchronous and clears the controller and output valid.
// ----------------------------------------------------------------------------
module diffie_hellman_shared_secret #(
  parameter int unsigned MOD_BITS = dhss_pkg::MOD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dhss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [MOD_BITS-1:0]            cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dhss_pkg::KEY_BITS-1:0]  in_private_key_a,
  input  logic [dhss_pkg::KEY_BITS-1:0]  in_private_key_b,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [MOD_BITS-1:0]            out_public_a,
  output logic [MOD_BITS-1:0]            out_public_b,
  output logic [MOD_BITS-1:0]            out_shared_secret,
  output logic                           out_keys_agree
);

  dhss_pkg::dp_cmd_t    cmd;
  dhss_pkg::dp_status_t status;

  // Sequencer.
  dhss_ctrl #(.MOD_BITS(MOD_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and registers.
  dhss_datapath #(.MOD_BITS(MOD_BITS)) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_private_key_a  (in_private_key_a),
    .in_private_key_b  (in_private_key_b),
    .cmd               (cmd),
    .status            (status),
    .out_public_a      (out_public_a),
    .out_public_b      (out_public_b),
    .out_shared_secret (out_shared_secret),
    .out_keys_agree    (out_keys_agree)
  );

endmodule

// ===== sv/dhss_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhss_datapath
// Configuration registers, operand registers and a bit-serial modular
// multiplier used for square-and-multiply exponentiation.
// ----------------------------------------------------------------------------
module dhss_datapath #(
  parameter int unsigned MOD_BITS = dhss_pkg::MOD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dhss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [MOD_BITS-1:0]            cfg_data,
  input  logic [dhss_pkg::KEY_BITS-1:0]  in_private_key_a,
  input  logic [dhss_pkg::KEY_BITS-1:0]  in_private_key_b,
  input  dhss_pkg::dp_cmd_t              cmd,
  output dhss_pkg::dp_status_t           status,
  output logic [MOD_BITS-1:0]            out_public_a,
  output logic [MOD_BITS-1:0]            out_public_b,
  output logic [MOD_BITS-1:0]            out_shared_secret,
  output logic                           out_keys_agree
);

  localparam int unsigned KB = dhss_pkg::KEY_BITS;

  logic [MOD_BITS-1:0] prime_r, gen_r;
  logic [KB-1:0]       ka_r, kb_r, ksh_r;
  logic [MOD_BITS-1:0] gsh_r, red_r, acc_r, base_r;
  logic [MOD_BITS-1:0] macc_r, ma_r, mb_r;
  logic [MOD_BITS-1:0] pa_r, pb_r, sa_r, sb_r;
  logic [MOD_BITS-1:0] opa_r, opb_r, osec_r;
  logic                oagree_r;
  logic [MOD_BITS:0]   red_sum;
  logic [MOD_BITS-1:0] red_nxt, macc_nxt, ma_nxt;

  // Sum of two residues reduced once; both operands are below the modulus.
  function automatic logic [MOD_BITS-1:0] add_mod(input logic [MOD_BITS-1:0] x,
                                                  input logic [MOD_BITS-1:0] y,
                                                  input logic [MOD_BITS-1:0] m);
    logic [MOD_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[MOD_BITS-1:0];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= MOD_BITS'(dhss_pkg::PRIME_RESET);
      gen_r   <= MOD_BITS'(dhss_pkg::GEN_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        dhss_pkg::CFG_PRIME_MODULUS: prime_r <= cfg_data;
        dhss_pkg::CFG_GENERATOR:     gen_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // One restoring reduction step of the generator, most significant bit first.
  assign red_sum = {red_r, gsh_r[MOD_BITS-1]};
  assign red_nxt = (red_sum >= {1'b0, prime_r}) ? MOD_BITS'(red_sum - {1'b0, prime_r})
                                                : red_sum[MOD_BITS-1:0];

  // One shift-and-add multiplier step.
  assign macc_nxt = mb_r[0] ? add_mod(macc_r, ma_r, prime_r) : macc_r;
  assign ma_nxt   = add_mod(ma_r, ma_r, prime_r);

  // Operand and result registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      dhss_pkg::DP_LOAD: begin
        ka_r  <= in_private_key_a;
        kb_r  <= in_private_key_b;
        gsh_r <= gen_r;
        red_r <= '0;
        pa_r  <= '0;
        pb_r  <= '0;
        sa_r  <= '0;
        sb_r  <= '0;
      end
      dhss_pkg::DP_RED: begin
        red_r <= red_nxt;
        gsh_r <= {gsh_r[MOD_BITS-2:0], 1'b0};
      end
      dhss_pkg::DP_EXP_INIT: begin
        acc_r <= MOD_BITS'(1);
        ksh_r <= cmd.phase[0] ? kb_r : ka_r;
        case (cmd.phase)
          dhss_pkg::PH_SEC_A: base_r <= pb_r;
          dhss_pkg::PH_SEC_B: base_r <= pa_r;
          default:            base_r <= red_r;
        endcase
      end
      dhss_pkg::DP_SQ_INIT: begin
        macc_r <= '0;
        ma_r   <= acc_r;
        mb_r   <= acc_r;
      end
      dhss_pkg::DP_MP_INIT: begin
        macc_r <= '0;
        ma_r   <= acc_r;
        mb_r   <= base_r;
      end
      dhss_pkg::DP_MUL_STEP: begin
        macc_r <= macc_nxt;
        ma_r   <= ma_nxt;
        mb_r   <= {1'b0, mb_r[MOD_BITS-1:1]};
      end
      dhss_pkg::DP_MUL_DONE: begin
        acc_r <= macc_r;
        if (cmd.shift_key) begin
          ksh_r <= {ksh_r[KB-2:0], 1'b0};
        end
      end
      dhss_pkg::DP_STORE: begin
        case (cmd.phase)
          dhss_pkg::PH_PUB_A: pa_r <= acc_r;
          dhss_pkg::PH_PUB_B: pb_r <= acc_r;
          dhss_pkg::PH_SEC_A: sa_r <= acc_r;
          default:            sb_r <= acc_r;
        endcase
      end
      dhss_pkg::DP_FINISH: begin
        opa_r    <= pa_r;
        opb_r    <= pb_r;
        oagree_r <= (sa_r == sb_r);
        osec_r   <= (sa_r == sb_r) ? sa_r : '0;
      end
      default: ;
    endcase
  end

  assign status.mod_small = (prime_r < MOD_BITS'(2));
  assign status.key_bit   = ksh_r[KB-1];

  assign out_public_a      = opa_r;
  assign out_public_b      = opb_r;
  assign out_shared_secret = osec_r;
  assign out_keys_agree    = oagree_r;

endmodule

// ===== sv/dhss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhss_ctrl
// Sequencer: generator reduction, four exponentiations and result handoff.
// ----------------------------------------------------------------------------
module dhss_ctrl #(
  parameter int unsigned MOD_BITS = dhss_pkg::MOD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  dhss_pkg::dp_status_t status,
  output dhss_pkg::dp_cmd_t    cmd
);

  localparam int unsigned CNT_W = $clog2(MOD_BITS);
  localparam int unsigned KW    = dhss_pkg::KEY_IDX_W;

  dhss_pkg::state_t state_r, state_nxt;
  dhss_pkg::phase_t phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [KW-1:0]    bit_r, bit_nxt;
  logic             sq_r, sq_nxt;
  logic             out_valid_r, out_valid_nxt;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dhss_pkg::ST_IDLE;
      phase_r     <= dhss_pkg::PH_PUB_A;
      cnt_r       <= '0;
      bit_r       <= '0;
      sq_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      bit_r       <= bit_nxt;
      sq_r        <= sq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    bit_nxt       = bit_r;
    sq_nxt        = sq_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd.op        = dhss_pkg::DP_NOP;
    cmd.phase     = phase_r;
    cmd.shift_key = 1'b0;
    unique case (state_r)
      dhss_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = dhss_pkg::DP_LOAD;
          cnt_nxt   = '0;
          phase_nxt = dhss_pkg::PH_PUB_A;
          state_nxt = dhss_pkg::ST_RED;
        end
      end
      dhss_pkg::ST_RED: begin
        if (status.mod_small) begin
          // A modulus below two gives all-zero residues.
          state_nxt = dhss_pkg::ST_FINISH;
        end else begin
          cmd.op  = dhss_pkg::DP_RED;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(MOD_BITS - 1)) begin
            state_nxt = dhss_pkg::ST_EXP_INIT;
          end
        end
      end
      dhss_pkg::ST_EXP_INIT: begin
        cmd.op    = dhss_pkg::DP_EXP_INIT;
        bit_nxt   = KW'(dhss_pkg::KEY_BITS - 1);
        state_nxt = dhss_pkg::ST_SQ_INIT;
      end
      dhss_pkg::ST_SQ_INIT: begin
        cmd.op    = dhss_pkg::DP_SQ_INIT;
        cnt_nxt   = '0;
        sq_nxt    = 1'b1;
        state_nxt = dhss_pkg::ST_MUL_RUN;
      end
      dhss_pkg::ST_MP_INIT: begin
        cmd.op    = dhss_pkg::DP_MP_INIT;
        cnt_nxt   = '0;
        sq_nxt    = 1'b0;
        state_nxt = dhss_pkg::ST_MUL_RUN;
      end
      dhss_pkg::ST_MUL_RUN: begin
        cmd.op  = dhss_pkg::DP_MUL_STEP;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MOD_BITS - 1)) begin
          state_nxt = dhss_pkg::ST_MUL_DONE;
        end
      end
      dhss_pkg::ST_MUL_DONE: begin
        cmd.op = dhss_pkg::DP_MUL_DONE;
        if (sq_r && status.key_bit) begin
          state_nxt = dhss_pkg::ST_MP_INIT;
        end else if (bit_r == '0) begin
          state_nxt = dhss_pkg::ST_STORE;
        end else begin
          cmd.shift_key = 1'b1;
          bit_nxt       = bit_r - KW'(1);
          state_nxt     = dhss_pkg::ST_SQ_INIT;
        end
      end
      dhss_pkg::ST_STORE: begin
        cmd.op = dhss_pkg::DP_STORE;
        if (phase_r == dhss_pkg::PH_SEC_B) begin
          state_nxt = dhss_pkg::ST_FINISH;
        end else begin
          phase_nxt = dhss_pkg::phase_t'(phase_r + 2'd1);
          state_nxt = dhss_pkg::ST_EXP_INIT;
        end
      end
      dhss_pkg::ST_FINISH: begin
        // Wait until the output register is free.
        if (!out_valid_r || !out_stall) begin
          cmd.op        = dhss_pkg::DP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = dhss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dhss_pkg::ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != dhss_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  // A new result appears only after the finish step.
  a_rise_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == dhss_pkg::ST_FINISH))
    else $error("result valid rose outside the finish step");

  // A held result is never overwritten.
  a_hold_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dhss_pkg::ST_FINISH && out_valid_r && out_stall)
      |=> (state_r == dhss_pkg::ST_FINISH && out_valid_r))
    else $error("finish step overran a stalled result");

  // The multiply always starts from a square before any key-bit multiply.
  a_mp_after_sq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dhss_pkg::ST_MP_INIT) |-> $past(state_r == dhss_pkg::ST_MUL_DONE) && sq_r)
    else $error("multiply step not preceded by a square");

endmodule
